@@ rtl/core/window_crossing_event_detector_core_defines.svh @@
// Assertion macros for the window crossing event detector core.
`ifndef WINDOW_CROSSING_EVENT_DETECTOR_CORE_DEFINES_SVH
`define WINDOW_CROSSING_EVENT_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WCED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wced check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define WCED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wced check failed: next-cycle implication");

`endif

@@ rtl/core/wced_pkg.sv @@
// Shared types and constants for the window crossing event detector core.
package wced_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int THRESH_WIDTH = 32;
    localparam int CMP_WIDTH    = (SAMPLE_WIDTH > THRESH_WIDTH) ? SAMPLE_WIDTH : THRESH_WIDTH;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int REG_IDX_WIDTH  = 3;

    typedef logic [REG_IDX_WIDTH-1:0] reg_idx_t;

    localparam reg_idx_t REG_LOWER_BOUND    = 3'd0;
    localparam reg_idx_t REG_UPPER_BOUND    = 3'd1;
    localparam reg_idx_t REG_REPEAT_MODE    = 3'd2;
    localparam reg_idx_t REG_BLOCK_ENABLE   = 3'd3;
    localparam reg_idx_t REG_ACTION_ENABLES = 3'd4;

    typedef enum logic [1:0] {
        ZONE_LOW  = 2'd0,
        ZONE_MID  = 2'd1,
        ZONE_HIGH = 2'd2
    } zone_t;

    typedef enum logic [1:0] {
        EV_FELL_LOW  = 2'd0,
        EV_ROSE_LOW  = 2'd1,
        EV_FELL_HIGH = 2'd2,
        EV_ROSE_HIGH = 2'd3
    } event_t;

endpackage

@@ rtl/core/window_crossing_event_detector_core.sv @@
// Window crossing event detector: zone classification, crossing events, APB registers.
// Takes one signed 16.16 sample per cycle and sorts it into below-low, in-window or
// at-or-above-high; a zone change (or, in repeat mode, an unchanged zone after a first
// event) yields one result carrying the event code and its log and feedback request bits.
// A sample passes an input register and then the result register, which holds a result
// until result_ready is high; the sustained rate is one sample per cycle and falls only
// when the result register is full and result_ready is low. The first sample after
// reset only sets the zone. Samples are dropped while block_enable is 0.
// Registers sit at byte addresses 0x00 lower window bound, 0x04 upper window bound,
// 0x08 repeat_mode, 0x0C block_enable, 0x10 action_enables; write them only while idle.
`include "window_crossing_event_detector_core_defines.svh"

module window_crossing_event_detector_core (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [wced_pkg::APB_ADDR_WIDTH-1:0]       paddr,
    input  logic [wced_pkg::APB_DATA_WIDTH-1:0]       pwdata,
    output logic [wced_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                      pready,
    input  logic                                      sample_valid,
    output logic                                      sample_ready,
    input  logic signed [wced_pkg::SAMPLE_WIDTH-1:0]  sample,
    output logic                                      result_valid,
    input  logic                                      result_ready,
    output logic [1:0]                                event_code,
    output logic                                      log_request,
    output logic                                      feedback_request
);
    import wced_pkg::*;

    // configuration
    logic signed [THRESH_WIDTH-1:0] lower_bound_reg;
    logic signed [THRESH_WIDTH-1:0] upper_bound_reg;
    logic                           repeat_mode_reg;
    logic                           block_enable_reg;
    logic [7:0]                     action_enables_reg;

    // detector state
    zone_t  zone_reg, zone_next;
    logic   zone_known_reg, zone_known_next;
    logic   prev_valid_reg, prev_valid_next;
    event_t prev_event_reg, prev_event_next;

    // pipeline
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           res_valid_reg, res_valid_next;
    event_t                         res_event_reg, res_event_next;
    logic                           res_log_reg, res_log_next;
    logic                           res_fb_reg, res_fb_next;

    logic                           cfg_write;
    reg_idx_t                       cfg_idx;
    logic                           stage_go;
    logic                           emit;
    event_t                         emit_code;
    zone_t                          new_zone;
    logic signed [CMP_WIDTH-1:0]    s_ext, lo_ext, hi_ext;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg    <= '0;
            upper_bound_reg    <= '0;
            repeat_mode_reg    <= 1'b1;
            block_enable_reg   <= 1'b0;
            action_enables_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_LOWER_BOUND:    lower_bound_reg    <= pwdata[THRESH_WIDTH-1:0];
                REG_UPPER_BOUND:    upper_bound_reg    <= pwdata[THRESH_WIDTH-1:0];
                REG_REPEAT_MODE:    repeat_mode_reg    <= pwdata[0];
                REG_BLOCK_ENABLE:   block_enable_reg   <= pwdata[0];
                REG_ACTION_ENABLES: action_enables_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_LOWER_BOUND:    prdata = APB_DATA_WIDTH'(unsigned'(lower_bound_reg));
            REG_UPPER_BOUND:    prdata = APB_DATA_WIDTH'(unsigned'(upper_bound_reg));
            REG_REPEAT_MODE:    prdata = APB_DATA_WIDTH'(repeat_mode_reg);
            REG_BLOCK_ENABLE:   prdata = APB_DATA_WIDTH'(block_enable_reg);
            REG_ACTION_ENABLES: prdata = APB_DATA_WIDTH'(action_enables_reg);
            default:            prdata = '0;
        endcase
    end

    // input stage drains whenever the result slot is free or being emptied
    assign stage_go     = in_valid_reg && (!res_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample_ready)
            in_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            sample_reg <= sample;
    end

    // sign-extend both sides to a common width
    assign s_ext  = CMP_WIDTH'(sample_reg);
    assign lo_ext = CMP_WIDTH'(lower_bound_reg);
    assign hi_ext = CMP_WIDTH'(upper_bound_reg);

    always_comb
    begin
        priority if (s_ext < lo_ext)
            new_zone = ZONE_LOW;
        else if (s_ext < hi_ext)
            new_zone = ZONE_MID;
        else
            new_zone = ZONE_HIGH;
    end

    always_comb
    begin
        zone_next       = zone_reg;
        zone_known_next = zone_known_reg;
        prev_valid_next = prev_valid_reg;
        prev_event_next = prev_event_reg;
        emit            = 1'b0;
        emit_code       = prev_event_reg;

        if (stage_go && block_enable_reg)
        begin
            if (!zone_known_reg)
            begin
                zone_next       = new_zone;
                zone_known_next = 1'b1;
            end
            else if (new_zone == zone_reg)
            begin
                emit = repeat_mode_reg && prev_valid_reg;
            end
            else
            begin
                unique case (new_zone)
                    ZONE_LOW:  emit_code = EV_FELL_LOW;
                    ZONE_HIGH: emit_code = EV_ROSE_HIGH;
                    default:   emit_code = (zone_reg == ZONE_LOW) ? EV_ROSE_LOW : EV_FELL_HIGH;
                endcase
                emit            = 1'b1;
                zone_next       = new_zone;
                prev_valid_next = 1'b1;
                prev_event_next = emit_code;
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg && !result_ready;
        res_event_next = res_event_reg;
        res_log_next   = res_log_reg;
        res_fb_next    = res_fb_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
            res_event_next = emit_code;
            res_log_next   = action_enables_reg[{1'b0, emit_code}];
            res_fb_next    = action_enables_reg[{1'b1, emit_code}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg       <= ZONE_LOW;
            zone_known_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_event_reg <= EV_FELL_LOW;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            zone_reg       <= zone_next;
            zone_known_reg <= zone_known_next;
            prev_valid_reg <= prev_valid_next;
            prev_event_reg <= prev_event_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_event_reg <= res_event_next;
        res_log_reg   <= res_log_next;
        res_fb_reg    <= res_fb_next;
    end

    assign result_valid     = res_valid_reg;
    assign event_code       = res_event_reg;
    assign log_request      = res_log_reg;
    assign feedback_request = res_fb_reg;

    // the sample that only sets the zone must never produce a result
    `WCED_ASSERT_NEXT(a_first_sample_silent, stage_go && block_enable_reg && !zone_known_reg, !res_valid_reg)
    // a result can only exist once some crossing event has been recorded
    `WCED_ASSERT_SAME(a_result_after_event, res_valid_reg, prev_valid_reg)
    // zone only moves when an item leaves the input stage
    `WCED_ASSERT_NEXT(a_zone_holds_when_idle, !stage_go, $stable(zone_reg) && $stable(zone_known_reg))

endmodule
